[hdl/double_press_button_detector_macros.svh]
// Assertion helpers for the double-press detector checkers.
// Both expect signals named clk and rst in the scope that uses them.
`ifndef DOUBLE_PRESS_BUTTON_DETECTOR_MACROS_SVH
`define DOUBLE_PRESS_BUTTON_DETECTOR_MACROS_SVH

// Same-cycle implication, held off during reset.
`define DPBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define DPBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dpbd_pkg.sv]
package dpbd_pkg;

  localparam int IN_BYTES_W  = 8;
  localparam int OUT_BYTES_W = 8;

  // register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_SETTLE = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_CANCEL = 2'd2;
  localparam logic [1:0] REG_ACTIVE = 2'd3;

  localparam logic [15:0] SETTLE_RESET = 16'd50;
  localparam logic [15:0] WINDOW_RESET = 16'd2000;
  localparam logic [15:0] CANCEL_RESET = 16'd5000;
  localparam logic        ACTIVE_RESET = 1'b0;

  // detector state codes
  localparam logic [1:0] STATE_CLEAR    = 2'd0;
  localparam logic [1:0] STATE_FIRST    = 2'd1;
  localparam logic [1:0] STATE_RELEASED = 2'd2;
  localparam logic [1:0] STATE_PRESSED  = 2'd3;

  // bit positions in the input and result data
  localparam int IN_PIN_BIT     = 0;
  localparam int IN_READ_BIT    = 1;
  localparam int OUT_READ_BIT   = 0;
  localparam int OUT_NOTIFY_BIT = 1;
  localparam int OUT_ON_BIT     = 2;
  localparam int OUT_STATE_LSB  = 3;

endpackage

[hdl/double_press_button_detector.sv]
// Double-press button detector, one input item per millisecond tick.
// The result of an accepted item is registered and shows on the m_ side in the next cycle.
// Throughput: 1 item per cycle; s_tready drops only while a result is held.
// Reset (rst, synchronous, active high): state clear, all timers idle,
// previous pin at the inactive level, registers back to 50/2000/5000/0.
module double_press_button_detector
  import dpbd_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // input items
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_BYTES_W-1:0]  s_tdata,   // [0] button_pin, [1] status_read, rest zero
  // result items
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_BYTES_W-1:0] m_tdata,   // [0] read_pressed, [1] notify,
                                            // [2] notify_is_on, [4:3] detector_state
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int TW = TIMER_WIDTH;
  // largest count a timer holds, in a width that covers any TIMER_WIDTH up to 32
  localparam logic [32:0] TMAX = (33'd1 << TW) - 33'd1;

  typedef enum logic [1:0] {
    ST_CLEAR    = STATE_CLEAR,
    ST_FIRST    = STATE_FIRST,
    ST_RELEASED = STATE_RELEASED,
    ST_PRESSED  = STATE_PRESSED
  } press_state_t;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [15:0] settle_ticks;
  logic [15:0] double_window_ticks;
  logic [15:0] cancel_ticks;
  logic        active_level;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks        <= SETTLE_RESET;
      double_window_ticks <= WINDOW_RESET;
      cancel_ticks        <= CANCEL_RESET;
      active_level        <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SETTLE: settle_ticks        <= pwdata[15:0];
        REG_WINDOW: double_window_ticks <= pwdata[15:0];
        REG_CANCEL: cancel_ticks        <= pwdata[15:0];
        REG_ACTIVE: active_level        <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SETTLE: prdata = {16'd0, settle_ticks};
      REG_WINDOW: prdata = {16'd0, double_window_ticks};
      REG_CANCEL: prdata = {16'd0, cancel_ticks};
      REG_ACTIVE: prdata = {31'd0, active_level};
    endcase
  end

  // A register value of zero loads as one tick; values past the timer
  // width saturate.
  function automatic logic [TW-1:0] load_ticks(input logic [15:0] r);
    logic [32:0] ext;
    ext = {17'd0, r};
    if (r == 16'd0)
      return TW'(1);
    else if (ext > TMAX)
      return TMAX[TW-1:0];
    else
      return ext[TW-1:0];
  endfunction

  // ---------------------------------------------------------------
  // Detector state
  // ---------------------------------------------------------------
  press_state_t  press_state, press_state_next;
  logic          previous_pin;
  logic [TW-1:0] settle_count, settle_count_next;
  logic [TW-1:0] window_count, window_count_next;
  logic [TW-1:0] cancel_count, cancel_count_next;

  logic pin, rd, accept;
  logic read_hit, settle_fire, window_fire, cancel_fire;
  logic read_pressed_next, notify_next, notify_on_next;
  logic [TW-1:0] window_after_read, cancel_after_read;

  assign pin      = s_tdata[IN_PIN_BIT];
  assign rd       = s_tdata[IN_READ_BIT];
  // the result register frees up in the same cycle it is drained
  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;

  always_comb begin
    // read first: a latched press is returned and cleared with its timers
    read_hit          = rd && (press_state == ST_PRESSED);
    press_state_next  = read_hit ? ST_CLEAR : press_state;
    window_after_read = read_hit ? '0 : window_count;
    cancel_after_read = read_hit ? '0 : cancel_count;

    // countdowns: a timer fires on the tick it reaches zero
    settle_fire       = (settle_count == TW'(1));
    window_fire       = (window_after_read == TW'(1));
    cancel_fire       = (cancel_after_read == TW'(1));
    settle_count_next = (settle_count != '0) ? settle_count - TW'(1) : settle_count;
    window_count_next = (window_after_read != '0) ?
                        window_after_read - TW'(1) : window_after_read;
    cancel_count_next = (cancel_after_read != '0) ?
                        cancel_after_read - TW'(1) : cancel_after_read;

    read_pressed_next = read_hit;
    notify_next       = 1'b0;
    notify_on_next    = 1'b0;

    // settled level moves the press sequence along; a reload of a timer
    // overrides its expiry in the same tick
    if (settle_fire) begin
      if (pin == active_level) begin
        if (press_state_next == ST_CLEAR) begin
          press_state_next  = ST_FIRST;
          window_count_next = load_ticks(double_window_ticks);
          window_fire       = 1'b0;
        end else if (press_state_next == ST_RELEASED) begin
          press_state_next  = ST_PRESSED;
          notify_next       = 1'b1;
          notify_on_next    = 1'b1;
          cancel_count_next = load_ticks(cancel_ticks);
          cancel_fire       = 1'b0;
        end
      end else if (press_state_next == ST_FIRST) begin
        press_state_next  = ST_RELEASED;
        window_count_next = load_ticks(double_window_ticks);
        window_fire       = 1'b0;
      end
    end

    // second press too slow: drop the partial sequence
    if (window_fire && press_state_next != ST_PRESSED)
      press_state_next = ST_CLEAR;

    // detected press times out and is cancelled
    if (cancel_fire) begin
      press_state_next = ST_CLEAR;
      notify_next      = 1'b1;
      notify_on_next   = 1'b0;
    end

    // pin edge restarts debounce unless a press is latched
    if (pin != previous_pin && press_state_next != ST_PRESSED)
      settle_count_next = load_ticks(settle_ticks);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_state  <= ST_CLEAR;
      previous_pin <= ~ACTIVE_RESET;
      settle_count <= '0;
      window_count <= '0;
      cancel_count <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (accept) begin
        press_state  <= press_state_next;
        previous_pin <= pin;
        settle_count <= settle_count_next;
        window_count <= window_count_next;
        cancel_count <= cancel_count_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid     <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted item; upper bits zero
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= OUT_BYTES_W'({press_state_next, notify_on_next, notify_next,
                               read_pressed_next});
    end
  end

endmodule

[hdl/dpbd_checker.sv]
`include "double_press_button_detector_macros.svh"

module dpbd_checker
  import dpbd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_BYTES_W-1:0] m_tdata
);

  logic [1:0] out_state;
  assign out_state = m_tdata[OUT_STATE_LSB+1:OUT_STATE_LSB];

  // a press-detected notify always leaves the detector latched
  `DPBD_ASSERT_NOW(a_on_means_pressed, m_tvalid && m_tdata[OUT_ON_BIT], m_tdata[OUT_NOTIFY_BIT] && out_state == STATE_PRESSED, "notify_is_on without a latched press")

  // an acknowledged read clears the press, no new detection in that tick
  `DPBD_ASSERT_NOW(a_read_clears, m_tvalid && m_tdata[OUT_READ_BIT], out_state != STATE_PRESSED && !m_tdata[OUT_ON_BIT], "read_pressed but press still latched")

  // items keep flowing while a result is being drained
  `DPBD_ASSERT_NOW(a_no_bubble, m_tready || !m_tvalid, s_tready, "input stalled with result side free")

  // a stalled result holds
  `DPBD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

endmodule

bind double_press_button_detector dpbd_checker u_dpbd_checker (.*);

[sim/tb_double_press_button_detector.sv]
`timescale 1ns / 100ps

module tb_double_press_button_detector;
  import dpbd_pkg::*;

  // One result item, laid out as m_tdata[4:0]: state, notify_is_on, notify, read_pressed
  typedef struct packed {
    logic [1:0] state;
    logic       on;
    logic       notify;
    logic       pressed;
  } result_t;

  // Directed row: optional reconfigure first, then one tick item.
  // typed = 1 means res holds the hand-written expectation.
  typedef struct packed {
    logic    reconfig;
    logic    pin;
    logic    rd;
    logic    typed;
    result_t res;
  } dir_row_t;

  localparam result_t IDLE_RES = '{STATE_CLEAR, 1'b0, 1'b0, 1'b0};
  localparam result_t NO_RES   = '0;

  // Short timers for the directed walk; settle 0 must load as one tick
  localparam logic [15:0] DIR_SETTLE = 16'd0;
  localparam logic [15:0] DIR_WINDOW = 16'd3;
  localparam logic [15:0] DIR_CANCEL = 16'd4;
  localparam logic [15:0] DIR_ACTIVE = 16'd0;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // reset settings: pin at inactive level, plain tick, then read with nothing latched
    '{1'b0, 1'b1, 1'b0, 1'b1, IDLE_RES},
    '{1'b0, 1'b1, 1'b1, 1'b1, IDLE_RES},
    // first double press, then read it back
    '{1'b1, 1'b0, 1'b0, 1'b0, NO_RES},   // press edge
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},   // settles -> first press
    '{1'b0, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b1, 1'b0, 1'b0, NO_RES},   // -> released
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},   // -> pressed, notify on
    '{1'b0, 1'b1, 1'b0, 1'b0, NO_RES},   // edge while pressed is ignored
    '{1'b0, 1'b1, 1'b1, 1'b0, NO_RES},   // read finds press, clears
    // second double press, left to the cancel timer
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},   // pressed, cancel armed
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},   // cancel fires, notify off
    // settle restarted on its expiry tick, read during first press,
    // then the window runs out
    '{1'b0, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b1, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_RES}    // window expires -> clear
  };

  // Random phases: timer settings incl. zero and full-scale values
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 300;
  localparam logic [15:0] PH_SETTLE [PHASES] = '{16'd2, 16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd4};
  localparam logic [15:0] PH_WINDOW [PHASES] = '{16'd12, 16'd1, 16'd0, 16'hFFFF, 16'd5, 16'd25};
  localparam logic [15:0] PH_CANCEL [PHASES] = '{16'd20, 16'd1, 16'd0, 16'hFFFF, 16'd8, 16'd40};
  localparam logic [15:0] PH_ACTIVE [PHASES] = '{16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd1};

  localparam int HOLD_CYCLES = 64;   // long receiver stall, fills the output buffer

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;        // [0] button_pin, [1] status_read, rest zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;             // [0] read_pressed, [1] notify, [2] notify_is_on,
                                    // [4:3] detector_state
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  double_press_button_detector #(.TIMER_WIDTH(16)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Mirror of the detector: registers and state, at reset values
  logic [15:0] cfg_settle = SETTLE_RESET;
  logic [15:0] cfg_window = WINDOW_RESET;
  logic [15:0] cfg_cancel = CANCEL_RESET;
  logic        cfg_active = ACTIVE_RESET;
  logic [1:0]  det_state  = STATE_CLEAR;
  logic        prev_pin   = ~ACTIVE_RESET;
  logic [15:0] settle_cnt = '0;
  logic [15:0] window_cnt = '0;
  logic [15:0] cancel_cnt = '0;

  result_t due_results [$];   // one per accepted tick, oldest first
  int      fail_count = 0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;      // bumped by the stimulus side
  int hold_seen = 0;          // receiver side only
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Zero length loads as one tick; 16-bit registers never exceed the timer
  function automatic logic [15:0] timer_load(input logic [15:0] len);
    return (len == 16'd0) ? 16'd1 : len;
  endfunction

  // One tick: read, then expiries (settle, window, cancel), then edge
  task automatic advance_detector(input logic pin, input logic rd, output result_t res);
    logic s_fire;
    logic w_fire;
    logic c_fire;
    res = '0;
    if (rd && det_state == STATE_PRESSED) begin
      res.pressed = 1'b1;
      det_state   = STATE_CLEAR;
      window_cnt  = '0;
      cancel_cnt  = '0;
    end

    s_fire = (settle_cnt == 16'd1);
    w_fire = (window_cnt == 16'd1);
    c_fire = (cancel_cnt == 16'd1);
    if (settle_cnt != 0) settle_cnt = settle_cnt - 16'd1;
    if (window_cnt != 0) window_cnt = window_cnt - 16'd1;
    if (cancel_cnt != 0) cancel_cnt = cancel_cnt - 16'd1;

    if (s_fire) begin
      if (pin == cfg_active) begin
        if (det_state == STATE_CLEAR) begin
          det_state  = STATE_FIRST;
          window_cnt = timer_load(cfg_window);
          w_fire     = 1'b0;
        end else if (det_state == STATE_RELEASED) begin
          det_state  = STATE_PRESSED;
          res.notify = 1'b1;
          res.on     = 1'b1;
          cancel_cnt = timer_load(cfg_cancel);
          c_fire     = 1'b0;
        end
      end else if (det_state == STATE_FIRST) begin
        det_state  = STATE_RELEASED;
        window_cnt = timer_load(cfg_window);
        w_fire     = 1'b0;
      end
    end

    // window only reverts a partial sequence
    if (w_fire && det_state != STATE_PRESSED) det_state = STATE_CLEAR;

    if (c_fire) begin
      det_state  = STATE_CLEAR;
      res.notify = 1'b1;
      res.on     = 1'b0;
    end

    // edges are ignored once a press is latched
    if (pin != prev_pin && det_state != STATE_PRESSED) settle_cnt = timer_load(cfg_settle);
    prev_pin  = pin;
    res.state = det_state;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Offer one tick item; called and returning at a falling edge.
  // The expectation is computed at the edge that accepts the item.
  task automatic send_item(input logic pin, input logic rd, input logic typed,
                           input result_t typed_res);
    result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, rd, pin};
    do @(posedge clk); while (!s_tready);
    advance_detector(pin, rd, predicted);
    due_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Sender pause until every result is back; the block then sits idle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  // APB write then read-back of one register; mirror updated on the write
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SETTLE: cfg_settle = value;
      REG_WINDOW: cfg_window = value;
      REG_CANCEL: cfg_cancel = value;
      REG_ACTIVE: cfg_active = value[0];
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = (idx == REG_ACTIVE) ? {31'b0, value[0]} : {16'h0000, value};
    if (prdata !== want) begin
      $display("%0t: register %0d read-back mismatch, expected %h, actual %h",
               $time, idx, want, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] settle, input logic [15:0] window,
                           input logic [15:0] cancel, input logic [15:0] active);
    write_reg(REG_SETTLE, settle);
    write_reg(REG_WINDOW, window);
    write_reg(REG_CANCEL, cancel);
    write_reg(REG_ACTIVE, active);
  endtask

  // Pin held in runs: mostly long enough to settle (so real double presses
  // happen), some single-tick glitches, some long holds that let the
  // window and cancel timers run out. Reads are sprinkled at random.
  task automatic press_traffic(input int count);
    int   sent;
    int   len;
    int   roll;
    int   s_eff;
    logic lvl;
    s_eff = (cfg_settle == 0) ? 1 : ((cfg_settle > 6) ? 6 : int'(cfg_settle));
    lvl   = 1'($urandom_range(0, 1));
    sent  = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) len = 1;
      else if (roll < 8) len = $urandom_range(s_eff, s_eff + 3);
      else len = $urandom_range(1, 40);
      for (int k = 0; k < len && sent < count; k++) begin
        send_item(lvl, $urandom_range(0, 15) == 0, 1'b0, NO_RES);
        sent++;
      end
      lvl = ~lvl;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result checker, field by field against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b", $time, m_tdata[4:0]);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("read_pressed", want.pressed, m_tdata[OUT_READ_BIT]);
        check_field("notify", want.notify, m_tdata[OUT_NOTIFY_BIT]);
        check_field("notify_is_on", want.on, m_tdata[OUT_ON_BIT]);
        check_field("detector_state", want.state, m_tdata[OUT_STATE_LSB +: 2]);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed walk: sender mostly busy, receiver mostly stalled
    tx_idle_pct = 15;
    rx_idle_pct = 77;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].reconfig) begin
        drain();
        configure(DIR_SETTLE, DIR_WINDOW, DIR_CANCEL, DIR_ACTIVE);
      end
      send_item(DIRECTED[i].pin, DIRECTED[i].rd, DIRECTED[i].typed, DIRECTED[i].res);
    end

    // random phases; idle pattern swaps after the first two phases, no idling in the last two
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < 2) begin
        tx_idle_pct = 15;
        rx_idle_pct = 77;
      end else if (p < 4) begin
        tx_idle_pct = 77;
        rx_idle_pct = 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      configure(PH_SETTLE[p], PH_WINDOW[p], PH_CANCEL[p], PH_ACTIVE[p]);
      hold_requests = hold_requests + 1;   // back-pressure while items keep coming
      press_traffic(PHASE_ITEMS / 2);
      drain();
      press_traffic(PHASE_ITEMS / 2);
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[double_press_button_detector.f]
+incdir+hdl
hdl/dpbd_pkg.sv
hdl/double_press_button_detector.sv
hdl/dpbd_checker.sv
sim/tb_double_press_button_detector.sv
